// File: sv/modular_arithmetic_unit_defines.svh
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define MAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: sv/mau_pkg.sv
package mau_pkg;
  localparam int MOD_BITS_DEF = 31;
  localparam int EXP_BITS = 63;
  localparam int RAW_BITS = 64;
  localparam int OP_BITS = 3;
  localparam logic [30:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_RED = 3'd5
  } op_t;
endpackage

// File: sv/mau_if.sv
interface mau_in_if #(parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF) (input logic clk);
  logic                          valid;
  logic                          ready;
  logic [mau_pkg::OP_BITS-1:0]   op;
  logic [MOD_BITS-1:0]           operand_a;
  logic [MOD_BITS-1:0]           operand_b;
  logic [mau_pkg::EXP_BITS-1:0]  exponent;
  logic signed [mau_pkg::RAW_BITS-1:0] raw_value;
  modport source (output valid, op, operand_a, operand_b, exponent, raw_value, input ready);
  modport sink (input valid, op, operand_a, operand_b, exponent, raw_value, output ready);
endinterface

interface mau_out_if #(parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF) (input logic clk);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

interface mau_cfg_if #(parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF) (input logic clk);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/modular_arithmetic_unit.sv
// after accept, operands a and b are reduced bit-serially, then the op is dispatched:
// add/sub finish at dispatch, reduce shifts the raw value through the reduction step,
// mul runs shift-and-add, pow runs square-and-multiply, div raises b to modulus-2 then multiplies by a
// mul, pow and div use the one shared modular adder, one add or doubling per cycle
// one request at a time; next request accepted the cycle after the result is taken if cfg.valid is low
// synchronous active-high reset restores modulus to 1000000007, goes idle
module modular_arithmetic_unit #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  mau_in_if.sink    in_ch,
  mau_out_if.source out_ch,
  mau_cfg_if.sink   cfg
);
  localparam int EB = mau_pkg::EXP_BITS;
  localparam int RB = mau_pkg::RAW_BITS;
  localparam int CW = $clog2(RB + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_REDA  = 9'b000000010,
    S_REDB  = 9'b000000100,
    S_DISP  = 9'b000001000,
    S_RED   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_PWSTP = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  // what the multiplier result feeds
  typedef enum logic [1:0] {
    M_PLAIN = 2'd0, M_PACC = 2'd1, M_PSQ = 2'd2
  } mrole_t;

  state_t state;
  mrole_t mrole;
  logic [MOD_BITS-1:0] modulus, a, b, res, base, pacc;
  logic [MOD_BITS-1:0] mx, my, macc;
  logic [EB-1:0] e;
  logic [RB-1:0] rv;
  logic [MOD_BITS-1:0] rr;
  logic [CW-1:0] cnt;
  logic [mau_pkg::OP_BITS-1:0] op;
  logic neg, is_div;

  // shared unit: (x+y) mod m, inputs below m
  logic [MOD_BITS:0] su_s, su_d;
  logic [MOD_BITS-1:0] su_x, su_y, su_r;
  always_comb begin
    su_s = {1'b0, su_x} + {1'b0, su_y};
    su_d = su_s - {1'b0, modulus};
    su_r = su_d[MOD_BITS] ? su_s[MOD_BITS-1:0] : su_d[MOD_BITS-1:0];
  end

  // bit-serial reduction step: r = 2r + bit, then conditional subtract
  // operands a and b are shifted through it msb first, then the raw value
  logic rbit;
  logic [MOD_BITS:0] rs, rd;
  logic [MOD_BITS-1:0] rnext;
  always_comb begin
    rbit = rv[RB-1];
    if (state == S_REDA) rbit = a[MOD_BITS-1];
    else if (state == S_REDB) rbit = b[MOD_BITS-1];
    rs = {rr, rbit};
    rd = rs - {1'b0, modulus};
    rnext = rd[MOD_BITS] ? rs[MOD_BITS-1:0] : rd[MOD_BITS-1:0];
  end

  always_comb begin
    su_x = macc;
    su_y = mx;
    unique case (state)
      S_MUL: begin
        su_x = my[0] ? macc : mx;
        su_y = mx;
      end
      S_DISP: begin
        su_x = a;
        su_y = (op == mau_pkg::OP_SUB) ? ((b == '0) ? '0 : modulus - b) : b;
      end
      default: begin
        su_x = macc;
        su_y = mx;
      end
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready    = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.result = res;

  logic deg;
  assign deg = (modulus < MOD_BITS'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      modulus <= MOD_BITS'(mau_pkg::MOD_RESET);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            modulus <= cfg.data;
          end else if (in_ch.valid) begin
            op <= in_ch.op;
            a <= in_ch.operand_a;
            b <= in_ch.operand_b;
            e <= in_ch.exponent;
            rv <= in_ch.raw_value[RB-1] ? (~in_ch.raw_value + 1'b1) : in_ch.raw_value;
            neg <= in_ch.raw_value[RB-1];
            rr <= '0;
            cnt <= CW'(MOD_BITS);
            state <= S_REDA;
          end
        end
        S_REDA: begin
          if (deg) begin
            res <= '0;
            state <= S_OUT;
          end else if (cnt == '0) begin
            a <= rr;
            rr <= '0;
            cnt <= CW'(MOD_BITS);
            state <= S_REDB;
          end else begin
            rr <= rnext;
            a <= a << 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_REDB: begin
          if (cnt == '0) begin
            b <= rr;
            state <= S_DISP;
          end else begin
            rr <= rnext;
            b <= b << 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_DISP: begin
          mrole <= M_PLAIN;
          is_div <= 1'b0;
          case (op)
            mau_pkg::OP_ADD, mau_pkg::OP_SUB: begin
              res <= su_r;
              state <= S_OUT;
            end
            mau_pkg::OP_MUL: begin
              mx <= a; my <= b; macc <= '0;
              state <= S_MUL;
            end
            mau_pkg::OP_DIV: begin
              if (b == '0) begin
                res <= '0;
                state <= S_OUT;
              end else begin
                is_div <= 1'b1;
                base <= b;
                pacc <= MOD_BITS'(1);
                e <= EB'(modulus - MOD_BITS'(2));
                state <= S_PWSTP;
              end
            end
            mau_pkg::OP_POW: begin
              base <= a;
              pacc <= MOD_BITS'(1);
              state <= S_PWSTP;
            end
            mau_pkg::OP_RED: begin
              rr <= '0;
              cnt <= CW'(RB);
              state <= S_RED;
            end
            default: begin
              res <= '0;
              state <= S_OUT;
            end
          endcase
        end
        S_RED: begin
          if (cnt == '0) begin
            res <= (neg && rr != '0) ? modulus - rr : rr;
            state <= S_OUT;
          end else begin
            rr <= rnext;
            rv <= {rv[RB-2:0], 1'b0};
            cnt <= cnt - 1'b1;
          end
        end
        S_PWSTP: begin
          // one square-and-multiply step: first acc*base if bit set, then square; done when exponent is zero
          if (e == '0) begin
            if (is_div) begin
              mx <= a; my <= pacc; macc <= '0;
              mrole <= M_PLAIN;
              state <= S_MUL;
            end else begin
              res <= pacc;
              state <= S_OUT;
            end
          end else if (e[0] && mrole != M_PACC) begin
            mx <= pacc; my <= base; macc <= '0;
            mrole <= M_PACC;
            state <= S_MUL;
          end else begin
            mx <= base; my <= base; macc <= '0;
            mrole <= M_PSQ;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (my == '0) begin
            state <= S_FIN;
          end else if (my[0]) begin
            macc <= su_r;
            my[0] <= 1'b0;
          end else begin
            mx <= su_r;
            my <= my >> 1;
          end
        end
        S_FIN: begin
          unique case (mrole)
            M_PACC: begin
              pacc <= macc;
              state <= S_PWSTP;
            end
            M_PSQ: begin
              base <= macc;
              e <= e >> 1;
              mrole <= M_PLAIN;
              state <= S_PWSTP;
            end
            default: begin
              res <= macc;
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/mau_checker.sv
`include "modular_arithmetic_unit_defines.svh"
module mau_checker #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [MOD_BITS-1:0] result,
  input logic                cfg_ready
);
  // never take a request while a result waits
  `MAU_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input ready while result pending")
  `MAU_ASSERT_IMP(a_cfg_idle, out_valid, !cfg_ready, "config ready while busy")
  `MAU_ASSERT_NXT(a_busy_after, in_valid && in_ready, !in_ready, "ready right after accept")
  `MAU_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(result), "result dropped")
endmodule

bind modular_arithmetic_unit mau_checker #(.MOD_BITS(MOD_BITS)) u_mau_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result(out_ch.result), .cfg_ready(cfg.ready)
);
